### design/fer_pkg.sv
`timescale 1ns / 1ps

package fer_pkg;

  localparam int SAMPLE_W = 16;
  localparam int OUT_W    = 32;
  localparam int DELAY_W  = 10;
  localparam int ATT_W    = 4;
  localparam int CFG_W    = 10;
  localparam int IDX_W    = 2;
  localparam int GAIN_W   = 8;
  localparam int SHIFT_W  = 4;
  // 8 * delay needs three more bits than delay
  localparam int OFF_W    = DELAY_W + 3;

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ATTEN  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DELAY  = 2'd2;

  typedef enum logic [ATT_W-1:0] {
    ATT_UNITY   = 4'd1,
    ATT_HALF    = 4'd2,
    ATT_G85     = 4'd3,
    ATT_QUARTER = 4'd4,
    ATT_G51     = 4'd5,
    ATT_G43     = 4'd6,
    ATT_G37     = 4'd7,
    ATT_EIGHTH  = 4'd8
  } att_t;

  typedef struct packed {
    logic             enable;
    logic [ATT_W-1:0] atten;
  } mode_t;

  // gain multiplier per mode, zero for codes outside the list
  function automatic logic [GAIN_W-1:0] att_gain(input logic [ATT_W-1:0] a);
    logic [GAIN_W-1:0] g;
    case (att_t'(a))
      ATT_UNITY:   g = 8'd1;
      ATT_HALF:    g = 8'd1;
      ATT_G85:     g = 8'd85;
      ATT_QUARTER: g = 8'd1;
      ATT_G51:     g = 8'd51;
      ATT_G43:     g = 8'd43;
      ATT_G37:     g = 8'd37;
      ATT_EIGHTH:  g = 8'd1;
      default:     g = 8'd0;
    endcase
    return g;
  endfunction

  function automatic logic [SHIFT_W-1:0] att_shift(input logic [ATT_W-1:0] a);
    logic [SHIFT_W-1:0] s;
    case (att_t'(a))
      ATT_UNITY:   s = 4'd0;
      ATT_HALF:    s = 4'd1;
      ATT_G85:     s = 4'd8;
      ATT_QUARTER: s = 4'd2;
      ATT_G51:     s = 4'd8;
      ATT_G43:     s = 4'd8;
      ATT_G37:     s = 4'd8;
      ATT_EIGHTH:  s = 4'd3;
      default:     s = 4'd0;
    endcase
    return s;
  endfunction

  function automatic logic att_valid(input logic [ATT_W-1:0] a);
    logic v;
    case (att_t'(a))
      ATT_UNITY, ATT_HALF, ATT_G85, ATT_QUARTER,
      ATT_G51, ATT_G43, ATT_G37, ATT_EIGHTH: v = 1'b1;
      default: v = 1'b0;
    endcase
    return v;
  endfunction

endpackage

### design/fer_ram.sv
`timescale 1ns / 1ps

module fer_ram #(
  parameter int DEPTH = 8000,
  parameter int AW    = 13,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a shared address; the caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/fer_calc.sv
`timescale 1ns / 1ps

module fer_calc (
  input  fer_pkg::mode_t                  mode,
  input  logic signed [fer_pkg::SAMPLE_W-1:0] sample,
  input  logic [fer_pkg::OUT_W-1:0]       echo,
  output logic [fer_pkg::OUT_W-1:0]       y
);

  logic [fer_pkg::OUT_W-1:0]        s_ext;
  logic [fer_pkg::OUT_W-1:0]        prod;
  logic signed [fer_pkg::OUT_W-1:0] scaled;
  logic [fer_pkg::GAIN_W-1:0]       gain;
  logic [fer_pkg::SHIFT_W-1:0]      shamt;

  assign s_ext  = fer_pkg::OUT_W'(sample);
  assign gain   = fer_pkg::att_gain(mode.atten);
  assign shamt  = fer_pkg::att_shift(mode.atten);
  // product wraps at 32 bits before the arithmetic shift
  assign prod   = echo * {{(fer_pkg::OUT_W-fer_pkg::GAIN_W){1'b0}}, gain};
  assign scaled = $signed(prod) >>> shamt;

  always_comb begin
    if (!mode.enable) begin
      y = s_ext;
    end else if (fer_pkg::att_valid(mode.atten)) begin
      y = s_ext + $unsigned(scaled);
    end else begin
      y = '0;
    end
  end

endmodule

### design/feedback_echo_reverb_unit.sv
`timescale 1ns / 1ps
// path: an accepted word waits in the stage-1 registers, its result in out_data_r
// throughput: one word per cycle while not busy and out_tready keeps the output moving
// reset: after rst_n the echo store is swept to zero, with in_tready low until it ends
// a write to the delay register reduces the offset modulo DEPTH by reciprocal,
// in_tready stays low meanwhile; registers reset to enable 0, attenuation 1, delay 1
module feedback_echo_reverb_unit #(
  parameter int DEPTH = 8000
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // tdata: sample_in [15:0]
  input  logic [15:0]                  in_tdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // tdata: sample_out [31:0]
  output logic [31:0]                  out_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_we,
  input  logic [fer_pkg::IDX_W-1:0]    cfg_index,
  input  logic [fer_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OFF_W     = fer_pkg::OFF_W;
  localparam int SUB_W     = ((AW > OFF_W) ? AW : OFF_W) + 1;
  localparam int RED_STEPS = 2;
  localparam int CNT_W     = 2;
  localparam int DEP_W     = 17;
  // reciprocal of DEPTH, exact quotient for any offset below 2**OFF_W
  localparam int RCP_SH    = OFF_W + DEP_W;
  localparam int RCP_W     = RCP_SH - 2;
  localparam int PROD_W    = OFF_W + RCP_W;
  localparam int QD_W      = fer_pkg::DELAY_W + DEP_W;
  localparam logic [63:0] RECIP = ((64'd1 << RCP_SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam int OFF_RST   = 8 % DEPTH;

  // configuration
  logic                         enable_r;
  logic [fer_pkg::ATT_W-1:0]    atten_r;
  logic [OFF_W-1:0]             off_r;
  logic [OFF_W-1:0]             off_raw_r;
  logic [fer_pkg::DELAY_W-1:0]  quot_r;
  logic [CNT_W-1:0]             red_cnt_r;
  logic [PROD_W-1:0]            rcp_prod;
  logic [QD_W-1:0]              quot_dep;
  fer_pkg::mode_t               mode;

  // clearing sweep
  logic                         clr_busy_r;
  logic [AW-1:0]                clr_cnt_r;

  // pipeline
  logic [AW-1:0]                wp_r;
  logic                         s1_valid_r;
  logic [fer_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [AW-1:0]                s1_waddr_r;
  logic                         fwd_r;
  logic [fer_pkg::OUT_W-1:0]    fwd_data_r;
  logic                         out_valid_r;
  logic [fer_pkg::OUT_W-1:0]    out_data_r;

  logic                         busy;
  logic                         accept;
  logic                         s1_go;
  logic [SUB_W-1:0]             diff;
  logic [AW-1:0]                raddr;
  logic [fer_pkg::OUT_W-1:0]    rd_data;
  logic [fer_pkg::OUT_W-1:0]    echo;
  logic [fer_pkg::OUT_W-1:0]    y;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [fer_pkg::OUT_W-1:0]    mem_wdata;
  logic [AW-1:0]                wp_nxt;

  assign busy      = clr_busy_r || (red_cnt_r != '0);
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !busy && (!s1_valid_r || s1_go);
  assign accept    = in_tvalid && in_tready;

  // read position: write pointer minus offset, circular
  always_comb begin
    diff = SUB_W'(wp_r) - SUB_W'(off_r);
    if (diff[SUB_W-1]) begin
      diff = diff + SUB_W'(DEPTH);
    end
    raddr = diff[AW-1:0];
  end

  assign wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);

  assign mode.enable = enable_r;
  assign mode.atten  = atten_r;

  assign echo = fwd_r ? fwd_data_r : rd_data;

  fer_calc u_calc (
    .mode   (mode),
    .sample (s1_sample_r),
    .echo   (echo),
    .y      (y)
  );

  assign mem_we    = clr_busy_r || s1_go;
  assign mem_waddr = clr_busy_r ? clr_cnt_r : s1_waddr_r;
  assign mem_wdata = clr_busy_r ? '0 : y;

  fer_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (fer_pkg::OUT_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign rcp_prod = PROD_W'(off_raw_r) * PROD_W'(RECIP[RCP_W-1:0]);
  assign quot_dep = QD_W'(quot_r) * QD_W'(DEPTH);

  // configuration registers and offset reduction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      atten_r   <= fer_pkg::ATT_W'(fer_pkg::ATT_UNITY);
      off_r     <= OFF_W'(OFF_RST);
      off_raw_r <= '0;
      quot_r    <= '0;
      red_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fer_pkg::CFG_ENABLE: enable_r <= cfg_data[0];
          fer_pkg::CFG_ATTEN:  atten_r  <= cfg_data[fer_pkg::ATT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we && (cfg_index == fer_pkg::CFG_DELAY)) begin
        off_raw_r <= {cfg_data[fer_pkg::DELAY_W-1:0], 3'b000};
        red_cnt_r <= CNT_W'(RED_STEPS);
      end else if (red_cnt_r != '0) begin
        red_cnt_r <= red_cnt_r - CNT_W'(1);
      end
      // quotient by reciprocal, then remainder
      if (red_cnt_r == CNT_W'(2)) begin
        quot_r <= rcp_prod[RCP_SH +: fer_pkg::DELAY_W];
      end
      if (red_cnt_r == CNT_W'(1)) begin
        off_r <= off_raw_r - quot_dep[OFF_W-1:0];
      end
    end
  end

  // zero sweep of the store after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // control of the two stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      if (accept) begin
        wp_r  <= wp_nxt;
        // the word ahead writes this cycle, its value is not yet in the store
        fwd_r <= s1_go && (s1_waddr_r == raddr);
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample_r <= in_tdata;
      s1_waddr_r  <= wp_r;
      fwd_data_r  <= y;
    end
    if (s1_go) begin
      out_data_r <= y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready)
    else $error("word accepted during clear sweep or offset reduction");

  a_stage_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> (out_tvalid && out_tdata == $past(y)))
    else $error("result register missed a finished word");

  a_addr_range : assert property (@(posedge clk) disable iff (!rst_n)
    (!busy) |-> (wp_r < AW'(DEPTH - 1) || wp_r == AW'(DEPTH - 1)) && (off_r < OFF_W'(DEPTH)
      || DEPTH > 8191))
    else $error("pointer or offset outside the store");

  a_fwd_only_on_overlap : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !s1_go) |=> !fwd_r)
    else $error("forward flagged with no write in flight");

endmodule

### tb/reverb_echo_checker.sv
`timescale 1ns / 1ps

module reverb_echo_checker #(
  parameter int DEPTH = 8000
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [15:0]               in_tdata,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [31:0]               out_tdata,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_we,
  input  logic [fer_pkg::IDX_W-1:0] cfg_index,
  input  logic [fer_pkg::CFG_W-1:0] cfg_data,
  output int                        mismatches,
  output int                        pending
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // past outputs, indexed like the block's echo store
  logic [31:0]                 history [DEPTH];
  logic [AW-1:0]               wr_ptr;
  logic                        fx_on;
  logic [fer_pkg::ATT_W-1:0]   gain_sel;
  logic [fer_pkg::DELAY_W-1:0] echo_dly;
  logic [31:0]                 expected_samples [$];
  logic [31:0]                 want;

  // one reverb step: read the echo, scale it, add the input, store the sum (input alone when off)
  function automatic logic [31:0] predict_sample(input logic [15:0] w);
    logic [31:0] s;
    logic [31:0] y;
    logic [31:0] echo;
    logic [31:0] p;
    int          off;
    int          rd;
    s = {{16{w[15]}}, w};
    if (fx_on) begin
      off  = (int'(echo_dly) * 8) % DEPTH;
      rd   = (int'(wr_ptr) + DEPTH - off) % DEPTH;
      echo = history[AW'(rd)];
      case (gain_sel)
        fer_pkg::ATT_UNITY:   p = echo;
        fer_pkg::ATT_HALF:    p = $signed(echo) >>> 1;
        fer_pkg::ATT_G85:     p = $signed(echo * 32'd85) >>> 8;
        fer_pkg::ATT_QUARTER: p = $signed(echo) >>> 2;
        fer_pkg::ATT_G51:     p = $signed(echo * 32'd51) >>> 8;
        fer_pkg::ATT_G43:     p = $signed(echo * 32'd43) >>> 8;
        fer_pkg::ATT_G37:     p = $signed(echo * 32'd37) >>> 8;
        fer_pkg::ATT_EIGHTH:  p = $signed(echo) >>> 3;
        default:              p = '0;
      endcase
      // a code outside the gain list drops the input term as well
      y = (gain_sel >= fer_pkg::ATT_UNITY && gain_sel <= fer_pkg::ATT_EIGHTH) ? s + p : '0;
    end else begin
      y = s;
    end
    history[wr_ptr] = y;
    wr_ptr = (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
    return y;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) history[AW'(k)] = '0;
      wr_ptr   = '0;
      fx_on    = 1'b0;
      gain_sel = fer_pkg::ATT_UNITY;
      echo_dly = fer_pkg::DELAY_W'(1);
      expected_samples.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fer_pkg::CFG_ENABLE: fx_on    = cfg_data[0];
          fer_pkg::CFG_ATTEN:  gain_sel = cfg_data[fer_pkg::ATT_W-1:0];
          fer_pkg::CFG_DELAY:  echo_dly = cfg_data[fer_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_samples.push_back(predict_sample(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample_out with no word pending", out_tdata, '0);
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata !== want) report_mismatch("sample_out", out_tdata, want);
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

### tb/feedback_echo_reverb_unit_tb.sv
`timescale 1ns / 1ps

module feedback_echo_reverb_unit_tb;

  localparam int                        DEPTH       = 8000;
  localparam int                        HOLD_CYCLES = 300;
  localparam int                        FILL_WORDS  = 40;
  localparam int                        PHASES      = 16;
  localparam int                        PHASE_WORDS = 100;
  // gain codes outside the list
  localparam logic [fer_pkg::ATT_W-1:0] ATT_NONE    = 4'd0;
  localparam logic [fer_pkg::ATT_W-1:0] ATT_TOP     = 4'd15;
  localparam logic [15:0]               S_MAX       = 16'h7fff;
  localparam logic [15:0]               S_MIN       = 16'h8000;

  logic                      clk;
  logic                      rst_n;
  logic [15:0]               in_tdata;
  logic                      in_tvalid;
  logic                      in_tready;
  logic [31:0]               out_tdata;
  logic                      out_tvalid;
  logic                      out_tready;
  logic                      cfg_we;
  logic [fer_pkg::IDX_W-1:0] cfg_index;
  logic [fer_pkg::CFG_W-1:0] cfg_data;
  int                        fail_count;
  int                        pending;
  int                        tx_idle_pct;
  int                        rx_idle_pct;
  int                        hold_req;

  feedback_echo_reverb_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  reverb_echo_checker #(.DEPTH(DEPTH)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("feedback_echo_reverb_unit_tb: FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen  = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        out_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input logic [15:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = w;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [fer_pkg::IDX_W-1:0] idx,
                           input logic [fer_pkg::CFG_W-1:0] val);
    while (!in_tready) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // delay goes last since its write stalls the input for a while
  task automatic set_mode(input logic en, input logic [fer_pkg::ATT_W-1:0] att,
                          input logic [fer_pkg::DELAY_W-1:0] dly);
    drain;
    write_reg(fer_pkg::CFG_ENABLE, fer_pkg::CFG_W'(en));
    write_reg(fer_pkg::CFG_ATTEN, fer_pkg::CFG_W'(att));
    write_reg(fer_pkg::CFG_DELAY, fer_pkg::CFG_W'(dly));
  endtask

  function automatic logic [15:0] rand_sample;
    logic [15:0] w;
    case ($urandom_range(15))
      0:       w = S_MAX;
      1:       w = S_MIN;
      2:       w = '0;
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  initial begin : stimulus
    logic                        en;
    logic [fer_pkg::ATT_W-1:0]   att;
    logic [fer_pkg::DELAY_W-1:0] dly;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // store sweep after reset
    repeat (2) @(negedge clk);
    while (!in_tready) @(negedge clk);

    // reset values give pass-through
    send_word(S_MAX);
    send_word(S_MIN);
    send_word('0);
    send_word(16'hffff);

    set_mode(1'b1, fer_pkg::ATT_UNITY, 10'd1);
    for (int i = 0; i < 12; i++) send_word(i[0] ? S_MIN : S_MAX);

    // codes outside the gain list silence the output
    set_mode(1'b1, ATT_NONE, 10'd1);
    send_word(S_MAX);
    send_word(S_MIN);
    set_mode(1'b1, ATT_TOP, 10'd1);
    send_word(S_MAX);
    send_word(16'h1234);

    // short pass-through run ahead of the phases
    set_mode(1'b0, fer_pkg::ATT_UNITY, 10'd1);
    for (int i = 0; i < FILL_WORDS; i++) send_word(16'($urandom));

    for (int p = 0; p < PHASES; p++) begin
      if (p < 6) begin
        tx_idle_pct = 36;
        rx_idle_pct = 80;
      end else if (p < 11) begin
        tx_idle_pct = 80;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      en = (p < 8) ? 1'b1 : ($urandom_range(9) != 0);
      if (p < 8) begin
        att = fer_pkg::ATT_W'(fer_pkg::ATT_UNITY + p);
      end else if ($urandom_range(4) == 0) begin
        att = fer_pkg::ATT_W'($urandom_range(15));
      end else begin
        att = fer_pkg::ATT_W'(fer_pkg::ATT_UNITY + $urandom_range(7));
      end
      case (p)
        0: dly = '0;
        1: dly = 10'd1023;
        2: dly = 10'd1000;
        3: dly = 10'd1;
        default: begin
          case ($urandom_range(5))
            0:       dly = '0;
            1:       dly = 10'd1000;
            2:       dly = fer_pkg::DELAY_W'($urandom_range(1023, 1001));
            3:       dly = fer_pkg::DELAY_W'($urandom_range(4, 1));
            default: dly = fer_pkg::DELAY_W'($urandom_range(1023));
          endcase
        end
      endcase
      set_mode(en, att, dly);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // receiver stops for a long stretch while words keep coming
        if (p == 12 && i == 20) hold_req++;
        // sender waits until every word has come out
        if (p == 13 && i == 50) begin
          in_tvalid = 1'b0;
          while (pending != 0) @(negedge clk);
        end
        send_word(rand_sample());
      end
    end

    drain;
    repeat (6) @(negedge clk);
    if (fail_count == 0) begin
      $display("feedback_echo_reverb_unit_tb: PASS");
    end else begin
      $display("feedback_echo_reverb_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
